// ===== hw/rtl/hbmt_pkg.sv =====
// Package for the heartbeat membership table.
// Types, event codes, operation codes and table sizing. No dependencies.
package hbmt_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_CHECK  = 2'd1;
	localparam logic [1:0] OP_EXPORT = 2'd2;

	localparam logic [2:0] EV_DONE    = 3'd0;
	localparam logic [2:0] EV_ADDED   = 3'd1;
	localparam logic [2:0] EV_FAILED  = 3'd2;
	localparam logic [2:0] EV_REMOVED = 3'd3;
	localparam logic [2:0] EV_LIST    = 3'd4;
	localparam logic [2:0] EV_FULL    = 3'd5;
	localparam logic [2:0] EV_NULL    = 3'd6;

	localparam logic REG_FAIL   = 1'b0;
	localparam logic REG_REMOVE = 1'b1;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] hb;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] hb;
		logic        last;
	} result_t;
endpackage

// ===== hw/rtl/heartbeat_membership_table_core.sv =====
// Top level of the heartbeat membership table.
// Depends on hbmt_pkg and hbmt_ram.
//
// channel   direction  handshake       payload
// in        input      valid / stall   operation node_id node_port heartbeat_in force_update now
// out       output     valid / stall   event_res out_id out_port out_heartbeat last
// cfg       input      valid / ready   cfg_index cfg_data
//
// One item at a time. An update or an export walks the entry memory once, a timeout check
// twice (fail pass, then remove pass); each walk reads a stored entry, then decides and,
// where needed, writes it back; a removal adds a shift pass that moves each later entry down.
// A null update or an unused operation answers in the cycle after it is accepted.
// Each result waits in the output register until taken; decide steps hold meanwhile.
// Reset clears the entry count and sets the timeouts to 5 and 20; entry contents stay undefined.
module heartbeat_membership_table_core
	import hbmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] node_id,
	input  logic [15:0] node_port,
	input  logic signed [31:0] heartbeat_in,
	input  logic        force_update,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [31:0] out_id,
	output logic [15:0] out_port,
	output logic signed [31:0] out_heartbeat,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_SCAN2 = 3'd3;
	localparam logic [2:0] S_SHR   = 3'd4;
	localparam logic [2:0] S_SHW   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]       state_q;
	logic             pass2_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      fail_to_q, rem_to_q;
	logic [1:0]       op_q;
	logic [31:0]      id_q, now_q;
	logic [15:0]      port_q;
	logic [31:0]      hb_q;
	logic             force_q;
	logic             ov_q;
	result_t          res_q;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t           wdata, rd;

	hbmt_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
	);

	logic        busy_out;
	logic [31:0] silent;
	logic        hb_pos, hb_nz, match, lt;
	logic [32:0] mag;

	assign busy_out = ov_q && out_stall;
	assign silent   = now_q - rd.stamp;
	assign hb_pos   = !rd.hb[31] && (rd.hb != 32'd0);
	assign hb_nz    = rd.hb != 32'd0;
	assign match    = (rd.id == id_q) && (rd.port == port_q);
	assign mag      = rd.hb[31] ? (33'd0 - {rd.hb[31], rd.hb}) : {1'b0, rd.hb};
	assign lt       = !hb_q[31] && (mag < {1'b0, hb_q});

	assign in_stall  = state_q != S_IDLE || busy_out;
	assign cfg_ready = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign event_res = res_q.ev;
	assign out_id    = res_q.id;
	assign out_port  = res_q.port;
	assign out_heartbeat = res_q.hb;
	assign last      = res_q.last;

	always_comb begin
		raddr = idx_q[IDX_W-1:0];
		if (state_q == S_SHR) begin
			raddr = IDX_W'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			fail_to_q <= 16'd5;
			rem_to_q  <= 16'd20;
			ov_q      <= 1'b0;
			idx_q     <= '0;
			pass2_q   <= 1'b0;
			we        <= 1'b0;
		end else begin
			we <= 1'b0;
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FAIL) begin
					fail_to_q <= cfg_data;
				end else begin
					rem_to_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						op_q <= operation; id_q <= node_id; port_q <= node_port;
						hb_q <= heartbeat_in; force_q <= force_update; now_q <= now;
						idx_q <= '0;
						pass2_q <= 1'b0;
						if (operation == OP_UPDATE && node_id == 32'd0 && node_port == 16'd0) begin
							res_q <= '{EV_NULL, node_id, node_port, heartbeat_in, 1'b1};
							ov_q <= 1'b1;
						end else if (operation == OP_UPDATE || operation == OP_CHECK ||
							operation == OP_EXPORT) begin
							state_q <= S_READ;
						end else begin
							res_q <= '{EV_DONE, 32'd0, 16'd0, 32'd0, 1'b1};
							ov_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					if (idx_q >= count_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= pass2_q ? S_SCAN2 : S_EVAL;
					end
				end
				S_EVAL: begin
					if (!busy_out) begin
						state_q <= S_READ;
						idx_q <= idx_q + 1'b1;
						case (op_q)
							OP_UPDATE: begin
								if (match) begin
									res_q <= '{force_q ? EV_ADDED : EV_DONE, rd.id, rd.port,
										(lt || force_q) ? hb_q : rd.hb, 1'b1};
									ov_q <= 1'b1;
									state_q <= S_IDLE;
									if (lt || force_q) begin
										we <= 1'b1; waddr <= idx_q[IDX_W-1:0];
										wdata <= '{rd.id, rd.port, hb_q, now_q};
									end
								end
							end
							OP_CHECK: begin
								if (silent > {16'd0, fail_to_q} && hb_pos) begin
									res_q <= '{EV_FAILED, rd.id, rd.port, 32'd0 - rd.hb, 1'b0};
									ov_q <= 1'b1;
									we <= 1'b1; waddr <= idx_q[IDX_W-1:0];
									wdata <= '{rd.id, rd.port, 32'd0 - rd.hb, rd.stamp};
								end
							end
							OP_EXPORT: begin
								if (hb_pos && !(rd.id == 32'd0 && rd.port == 16'd0) && !match) begin
									res_q <= '{EV_LIST, rd.id, rd.port, rd.hb, 1'b0};
									ov_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN2: begin
					if (!busy_out) begin
						if (silent > {16'd0, rem_to_q} && hb_nz) begin
							res_q <= '{EV_REMOVED, rd.id, rd.port, rd.hb, 1'b0};
							ov_q <= 1'b1;
							state_q <= S_SHR;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_SHR: begin
					if (idx_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						idx_q <= count_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHW;
					end
				end
				S_SHW: begin
					we <= 1'b1; waddr <= idx_q[IDX_W-1:0]; wdata <= rd;
					idx_q <= idx_q + 1'b1;
					state_q <= S_SHR;
				end
				S_FIN: begin
					if (!busy_out) begin
						if (op_q == OP_CHECK && !pass2_q) begin
							pass2_q <= 1'b1;
							idx_q <= '0;
							state_q <= S_READ;
						end else if (op_q == OP_UPDATE) begin
							if (count_q >= CNT_W'(TABLE_DEPTH)) begin
								res_q <= '{EV_FULL, id_q, port_q, hb_q, 1'b1};
							end else begin
								res_q <= '{EV_ADDED, id_q, port_q, hb_q, 1'b1};
								we <= 1'b1; waddr <= count_q[IDX_W-1:0];
								wdata <= '{id_q, port_q, hb_q, now_q};
								count_q <= count_q + 1'b1;
							end
							ov_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							res_q <= '{EV_DONE, 32'd0, 16'd0, 32'd0, 1'b1};
							ov_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !$past(state_q != S_IDLE)) |-> !we)
		else $error("write while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |-> state_q == S_IDLE)
		else $error("final result while busy");
`endif
endmodule

// ===== hw/rtl/hbmt_ram.sv =====
// Entry memory of the membership table: one write port, one registered read port.
// Depends on hbmt_pkg.
module hbmt_ram
	import hbmt_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);
	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
